FILE: design/scanline_edgel_peak_detector_core_macros.svh
// Assertion macros for the scan-line edgel peak detector.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef SCANLINE_EDGEL_PEAK_DETECTOR_CORE_MACROS_SVH
`define SCANLINE_EDGEL_PEAK_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define SEPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SEPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SEPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEPD_ASSERT_ALWAYS(label, prop, msg)
`define SEPD_ASSERT_IMPL(label, ante, cons, msg)
`define SEPD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: design/sepd_pkg.sv
// Shared constants and types for the scan-line edgel peak detector.
// No dependencies.
`timescale 1ns / 1ps

package sepd_pkg;

  localparam int MAX_LINE_LENGTH = 4096;
  localparam int IDX_W  = $clog2(MAX_LINE_LENGTH + 1);
  localparam int POS_W  = 12;
  localparam int PIX_W  = 8;
  localparam int RESP_W = 9;
  localparam int CODE_W = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_SCAN  = 1'b1;

  localparam logic [RESP_W-1:0] THRESHOLD_RESET = 9'd16;

  localparam logic [CODE_W-1:0] MARK_HORIZONTAL = 2'd1;
  localparam logic [CODE_W-1:0] MARK_VERTICAL   = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [RESP_W-1:0] resp;
    logic              hit;
  } sepd_kern_t;

endpackage

FILE: design/sepd_kernel.sv
// Edge response and peak test for one window position.
// Depends on sepd_pkg.
`timescale 1ns / 1ps

module sepd_kernel (
  input  sepd_pkg::pix_t                  win0,
  input  sepd_pkg::pix_t                  win1,
  input  sepd_pkg::pix_t                  win3,
  input  sepd_pkg::pix_t                  pix,
  input  logic [sepd_pkg::RESP_W-1:0]     threshold,
  input  logic [sepd_pkg::RESP_W-1:0]     last_resp,
  input  logic [sepd_pkg::RESP_W-1:0]     older_resp,
  output sepd_pkg::sepd_kern_t            result
);
  import sepd_pkg::*;

  logic [RESP_W-1:0] left;
  logic [RESP_W-1:0] right;
  logic [RESP_W-1:0] diff;
  logic [RESP_W-1:0] resp;

  assign left  = RESP_W'(win0 >> 1) + RESP_W'(win1);
  assign right = RESP_W'(win3) + RESP_W'(pix >> 1);
  assign diff  = (right >= left) ? (right - left) : (left - right);
  assign resp  = (diff <= threshold) ? '0 : diff;

  assign result.resp = resp;
  assign result.hit  = (last_resp != '0) && (last_resp > older_resp) && (last_resp > resp);

endmodule

FILE: design/scanline_edgel_peak_detector_core.sv
// Top level of the scan-line edgel peak detector.
// Depends on sepd_pkg, sepd_kernel and the assertion macro header.
`timescale 1ns / 1ps
//
// Pixels of a scan line arrive on the in_ stream, one word per pixel, with
// in_tlast on the last pixel of the line. For every interior position whose
// thresholded edge response is a strict local maximum, one word leaves on the
// out_ stream carrying the position along the line and the scan direction code.
// A pixel enters an input register, then the window arithmetic and peak test
// run combinationally into the output register, whose word is offered on out_;
// one pixel is taken every cycle while the receiver does not stall.
// An edgel at index n-3 is reported for the word carrying pixel n.
// Lines longer than MAX_LINE_LENGTH have their extra pixels ignored until tlast.
// When the receiver stalls, the output word holds and the pipeline freezes;
// an empty input register takes one more word, then in_tready drops.
// Reset clears the line state, the pipeline and the registers (threshold 16,
// horizontal scan). Configuration is written through cfg_ with no handshake.
//

module scanline_edgel_peak_detector_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sepd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] pixel
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sepd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [11:0] position, [13:12] mark code
  input  logic                                cfg_we,
  input  logic [sepd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sepd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sepd_pkg::*;

  `include "scanline_edgel_peak_detector_core_macros.svh"

  logic [RESP_W-1:0] threshold_r;
  logic              vertical_r;

  logic       s1_v_r;
  pix_t       s1_pix_r;
  logic       s1_last_r;

  pix_t              win_r [4];
  logic [RESP_W-1:0] last_resp_r;
  logic [RESP_W-1:0] older_resp_r;
  logic [IDX_W-1:0]  idx_r;

  logic              out_v_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CODE_W-1:0] out_code_r;

  logic       adv;
  logic       proc;
  logic       in_range;
  sepd_kern_t kern;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign proc      = adv && s1_v_r;
  assign in_range  = idx_r < IDX_W'(MAX_LINE_LENGTH);

  sepd_kernel u_kernel (
    .win0       (win_r[0]),
    .win1       (win_r[1]),
    .win3       (win_r[3]),
    .pix        (s1_pix_r),
    .threshold  (threshold_r),
    .last_resp  (last_resp_r),
    .older_resp (older_resp_r),
    .result     (kern)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      vertical_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EDGE_THRESHOLD: threshold_r <= cfg_wdata[RESP_W-1:0];
        CFG_VERTICAL_SCAN:  vertical_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pix_r  <= in_tdata[PIX_W-1:0];
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
      last_resp_r  <= '0;
      older_resp_r <= '0;
      idx_r        <= '0;
    end else if (proc) begin
      if (s1_last_r) begin
        for (int i = 0; i < 4; i++) win_r[i] <= '0;
        last_resp_r  <= '0;
        older_resp_r <= '0;
        idx_r        <= '0;
      end else if (in_range) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= win_r[3];
        win_r[3] <= s1_pix_r;
        idx_r    <= idx_r + IDX_W'(1);
        if (idx_r >= IDX_W'(4)) begin
          older_resp_r <= last_resp_r;
          last_resp_r  <= kern.resp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= proc && in_range && (idx_r >= IDX_W'(4)) && kern.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_r  <= POS_W'(idx_r - IDX_W'(3));
      out_code_r <= vertical_r ? MARK_VERTICAL : MARK_HORIZONTAL;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - POS_W - CODE_W){1'b0}}, out_code_r, out_pos_r};

  `SEPD_ASSERT_IMPL(a_mark_code_valid, out_v_r, (out_code_r == MARK_HORIZONTAL) || (out_code_r == MARK_VERTICAL), "mark code out of range")
  `SEPD_ASSERT_ALWAYS(a_idx_bounded, idx_r <= IDX_W'(MAX_LINE_LENGTH), "pixel index beyond maximum line length")
  `SEPD_ASSERT_NEXT(a_line_clear, proc && s1_last_r, (idx_r == '0) && (last_resp_r == '0) && (older_resp_r == '0), "line state not cleared after last pixel")
  `SEPD_ASSERT_NEXT(a_idx_step, proc && !s1_last_r && in_range, idx_r == $past(idx_r) + IDX_W'(1), "pixel index did not advance")

endmodule

FILE: tb/scanline_edgel_peak_detector_core_test.sv
// Self-checking testbench for scanline_edgel_peak_detector_core: streams scan lines
// with random handshake gaps, predicts edgel words in a scoreboard and compares them.
// Depends on sepd_pkg and the design files of the core.
`timescale 1ns / 1ps

module scanline_edgel_peak_detector_core_test;
  import sepd_pkg::*;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
  } edgel_t;

  class edgel_scoreboard;
    logic [RESP_W-1:0] threshold;
    bit                vertical;
    logic [PIX_W-1:0]  win[4];
    logic [RESP_W-1:0] resp_last;
    logic [RESP_W-1:0] resp_older;
    logic [IDX_W-1:0]  line_pos;
    edgel_t            pending[$];
    int                errors;

    function new();
      threshold = THRESHOLD_RESET;
      vertical  = 1'b0;
      errors    = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (win[i]) win[i] = '0;
      resp_last  = '0;
      resp_older = '0;
      line_pos   = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_EDGE_THRESHOLD) threshold = value[RESP_W-1:0];
      else if (idx == CFG_VERTICAL_SCAN) vertical = value[0];
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, bit last_flag);
      int     lhs;
      int     rhs;
      int     resp;
      edgel_t hit;
      if (line_pos < MAX_LINE_LENGTH) begin
        if (line_pos >= 4) begin
          lhs  = (win[0] >> 1) + win[1];
          rhs  = win[3] + (pix >> 1);
          resp = (rhs >= lhs) ? rhs - lhs : lhs - rhs;
          if (resp <= threshold) resp = 0;
          if (resp_last > 0 && resp_last > resp_older && resp_last > resp) begin
            hit.pos  = POS_W'(line_pos - 3);
            hit.code = vertical ? MARK_VERTICAL : MARK_HORIZONTAL;
            pending.insert(pending.size(), hit);
          end
          resp_older = resp_last;
          resp_last  = RESP_W'(resp);
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = pix;
        line_pos++;
      end
      if (last_flag) clear_line();
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      edgel_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected edgel word: expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (word[11:0] !== want.pos) begin
        $display("%0t: edgel position: expected %0d, actual %0d", $time, want.pos, word[11:0]);
        errors++;
      end
      if (word[13:12] !== want.code) begin
        $display("%0t: mark code: expected %0d, actual %0d", $time, want.code, word[13:12]);
        errors++;
      end
      if (word[15:14] !== 2'b00) begin
        $display("%0t: padding bits: expected 0, actual %b", $time, word[15:14]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [7:0] pixel
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [11:0] position, [13:12] mark code
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  edgel_scoreboard sb;
  bit quiet = 1'b0;
  bit tx_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;
  bit long_hold = 1'b0;
  int rx_gap = 0;
  int in_count = 0;
  int line_left = 0;
  int level = 0;
  bit noisy = 1'b0;

  scanline_edgel_peak_detector_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (long_hold) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (!quiet && rx_stall_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      rx_gap <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Once an edgel word is waiting, keep the output stalled long enough to back up the input.
  initial begin
    do @(posedge clk); while (!(in_count >= 200 && out_tvalid && in_tvalid));
    long_hold <= 1'b1;
    repeat (120) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit last_flag);
    int gap;
    gap = 0;
    if (!quiet && tx_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(pix, last_flag);
    in_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Lines are mostly flat segments with small noise, so that steps give clean peaks.
  task automatic stream_pixels(input int n);
    int pix;
    for (int k = 0; k < n; k++) begin
      if (line_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1:    line_left = $urandom_range(1, 4);
          9:       line_left = $urandom_range(49, 300);
          default: line_left = $urandom_range(5, 48);
        endcase
        noisy = ($urandom_range(0, 5) == 0);
        level = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 3) == 0) level = $urandom_range(0, 1) ? 255 : 0;
        else level = $urandom_range(0, 255);
      end
      if (noisy) begin
        pix = $urandom_range(0, 255);
      end else begin
        pix = level + $urandom_range(0, 6) - 3;
        if (pix < 0) pix = 0;
        if (pix > 255) pix = 255;
      end
      send_pixel(PIX_W'(pix), line_left == 1);
      line_left--;
    end
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] thr;
    case ($urandom_range(0, 7))
      0:       thr = 9'd0;
      1:       thr = 9'd511;
      2:       thr = 9'd381;
      3:       thr = CFG_DATA_W'($urandom_range(0, 511));
      default: thr = CFG_DATA_W'($urandom_range(1, 120));
    endcase
    write_reg(CFG_EDGE_THRESHOLD, thr);
    if ($urandom_range(0, 1)) write_reg(CFG_VERTICAL_SCAN, CFG_DATA_W'($urandom_range(0, 1)));
  endtask

  initial begin
    int sent;
    logic [PIX_W-1:0] step_line[8];
    sb = new();
    step_line = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd200, 8'd255, 8'd255, 8'd40};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: too short, a step edge, a peak at the line end, a mid-line change.
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    foreach (step_line[i]) send_pixel(step_line[i], i == 7);
    for (int i = 0; i < 5; i++) send_pixel((i % 2) ? 8'd255 : 8'd0, i == 4);
    drain();
    write_reg(CFG_EDGE_THRESHOLD, 9'd0);
    write_reg(CFG_VERTICAL_SCAN, 9'd1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    drain();
    write_reg(CFG_EDGE_THRESHOLD, 9'd511);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b1);
    drain();
    write_reg(CFG_EDGE_THRESHOLD, THRESHOLD_RESET);
    write_reg(CFG_VERTICAL_SCAN, 9'd0);

    sent = 0;
    while (sent < 400) begin
      drain();
      random_config();
      tx_idle_on  <= ($urandom_range(0, 3) != 0);
      rx_stall_on <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
      stream_pixels($urandom_range(60, 160));
      sent = in_count;
    end

    while (in_count < 700) begin
      drain();
      random_config();
      tx_idle_on  <= ($urandom_range(0, 3) != 0);
      rx_stall_on <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
      stream_pixels($urandom_range(60, 160));
    end

    drain();
    write_reg(CFG_EDGE_THRESHOLD, 9'd8);
    quiet <= 1'b1;
    @(posedge clk);
    stream_pixels(100);
    stream_pixels(line_left);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/sepd_pkg.sv
design/sepd_kernel.sv
design/scanline_edgel_peak_detector_core.sv
tb/scanline_edgel_peak_detector_core_test.sv
